>>> rtl/ps2dcrs_pkg.sv
// Package: types, codes and constants of the PS/2 device command sequencer.
package ps2dcrs_pkg;

  localparam int unsigned TIMEOUT_WIDTH = 16;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned RETRY_W       = 4;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W   = QUEUE_PTR_W + 1;

  localparam logic [CFG_W-1:0]   SHORT_TIMEOUT_RST = CFG_W'(99);
  localparam logic [CFG_W-1:0]   LONG_TIMEOUT_RST  = CFG_W'(990);
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = RETRY_W'(10);

  localparam logic [7:0] BYTE_AUX_PREFIX = 8'hD4;
  localparam logic [7:0] BYTE_DISABLE    = 8'hF5;
  localparam logic [7:0] BYTE_ENABLE     = 8'hF4;
  localparam logic [7:0] BYTE_RESET      = 8'hFF;
  localparam logic [7:0] BYTE_BAT_PASS   = 8'hAA;
  localparam logic [7:0] BYTE_BAT_FAIL   = 8'hFC;
  localparam logic [7:0] BYTE_RESEND     = 8'hFE;
  localparam logic [7:0] BYTE_ACK        = 8'hFA;
  localparam logic [7:0] BYTE_ZERO       = 8'h00;

  localparam logic [1:0] PORT_AUX = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_TIMEOUT = 2'd0,
    REG_LONG_TIMEOUT  = 2'd1,
    REG_MAX_RETRIES   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    OP_DISABLE  = 2'd0,
    OP_ENABLE   = 2'd1,
    OP_SELFTEST = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ACT_CMD  = 2'd0,
    ACT_DATA = 2'd1,
    ACT_DONE = 2'd2
  } act_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DISABLE = 3'd1,
    PH_ENABLE  = 3'd2,
    PH_RESET   = 3'd3,
    PH_RESULT  = 3'd4,
    PH_DRAIN   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic       passed;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic       start;
    logic       rx;
    logic       tick;
    logic       retry;
    logic       wait_over;
    logic       fail;
    logic       enter;
    phase_e     next_phase;
    logic       send;
    logic [7:0] send_byte;
    logic       finish;
    logic       finish_ok;
  } event_t;

endpackage

>>> rtl/ps2dcrs_if.sv
// Interfaces: request and result channels of the PS/2 device command sequencer.
interface ps2dcrs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] operation;
  logic [1:0] target_port;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output operation, output target_port,
                  output rx_byte, input ready);
  modport sink (input valid, input req_type, input operation, input target_port,
                input rx_byte, output ready);
endinterface

interface ps2dcrs_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] byte_value;
  logic       passed;
  logic       last_of_run;

  modport source (output valid, output action, output byte_value, output passed,
                  output last_of_run, input ready);
  modport sink (input valid, input action, input byte_value, input passed,
                input last_of_run, output ready);
endinterface

>>> rtl/ps2_device_command_retry_sequencer_unit.sv
// Top level: PS/2 device command sequencer with resend retries and result queue.
// One request item (start, received byte or tick) is taken per clock while the
// four-entry result queue has room for two more results; each item updates the
// phase state in the same cycle and pushes zero, one or two results. Results
// leave the queue one per cycle, so the sustained rate is one item per cycle
// whenever the sink takes results as fast as they are produced; any command byte
// for an auxiliary-port device (start, resend, or the reset that follows the
// self-test disable phase) yields two results, the prefix and then the command byte.
module ps2_device_command_retry_sequencer_unit
  import ps2dcrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ps2dcrs_req_if.sink          req_i,
  ps2dcrs_rsp_if.source        rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [CFG_W-1:0]         short_to_q;
  logic [CFG_W-1:0]         long_to_q;
  logic [RETRY_W-1:0]       max_retries_q;

  phase_e                   phase_q, phase_d;
  logic [1:0]               op_q, op_d;
  logic                     port_q, port_d;
  logic [RETRY_W-1:0]       retry_q, retry_d;
  logic [TIMEOUT_WIDTH-1:0] quiet_q, quiet_d;

  result_t                  queue_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0]   count_q;

  event_t                   ev;
  logic                     accept;
  logic                     pop;
  logic [TIMEOUT_WIDTH-1:0] quiet_inc;
  logic [TIMEOUT_WIDTH-1:0] limit;
  logic                     give_up;
  logic [7:0]               cur_cmd;
  logic                     send_aux;
  logic [1:0]               n_res;
  result_t                  res0, res1;

  assign req_i.ready = (count_q < QUEUE_CNT_W'(QUEUE_DEPTH - 1));
  assign accept      = req_i.valid && req_i.ready;
  assign pop         = rsp_o.valid && rsp_o.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_to_q    <= SHORT_TIMEOUT_RST;
      long_to_q     <= LONG_TIMEOUT_RST;
      max_retries_q <= MAX_RETRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHORT_TIMEOUT: short_to_q    <= cfg_data_i;
        REG_LONG_TIMEOUT:  long_to_q     <= cfg_data_i;
        REG_MAX_RETRIES:   max_retries_q <= cfg_data_i[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign quiet_inc = (quiet_q == '1) ? quiet_q : quiet_q + TIMEOUT_WIDTH'(1);
  assign limit     = (phase_q == PH_RESULT) ? long_to_q : short_to_q;
  assign give_up   = ({1'b0, retry_q} + (RETRY_W+1)'(1)) >= {1'b0, max_retries_q};

  always_comb begin
    case (phase_q)
      PH_DISABLE: cur_cmd = BYTE_DISABLE;
      PH_ENABLE:  cur_cmd = BYTE_ENABLE;
      default:    cur_cmd = BYTE_RESET;
    endcase
  end

  // event decode
  always_comb begin
    ev = '0;
    ev.next_phase = PH_IDLE;
    if (accept) begin
      case (req_i.req_type)
        REQ_START: begin
          if (phase_q == PH_IDLE &&
              req_i.operation inside {OP_DISABLE, OP_ENABLE, OP_SELFTEST}) begin
            ev.start      = 1'b1;
            ev.enter      = 1'b1;
            ev.send       = 1'b1;
            ev.next_phase = (req_i.operation == OP_ENABLE) ? PH_ENABLE : PH_DISABLE;
            ev.send_byte  = (req_i.operation == OP_ENABLE) ? BYTE_ENABLE : BYTE_DISABLE;
          end
        end
        REQ_BYTE: begin
          if (phase_q != PH_IDLE) begin
            ev.rx = 1'b1;
            if (req_i.rx_byte == BYTE_ZERO) begin
              ev.wait_over = 1'b1;
            end else if (phase_q inside {PH_DISABLE, PH_ENABLE, PH_RESET}) begin
              if (req_i.rx_byte == BYTE_RESEND) begin
                if (give_up) begin
                  ev.wait_over = 1'b1;
                end else begin
                  ev.retry     = 1'b1;
                  ev.send      = 1'b1;
                  ev.send_byte = cur_cmd;
                end
              end else if (req_i.rx_byte == BYTE_ACK && phase_q != PH_DISABLE) begin
                ev.wait_over = 1'b1;
              end
            end else if (phase_q == PH_RESULT) begin
              if (req_i.rx_byte == BYTE_BAT_PASS) begin
                ev.wait_over = 1'b1;
              end else if (req_i.rx_byte == BYTE_BAT_FAIL) begin
                ev.wait_over = 1'b1;
                ev.fail      = 1'b1;
              end
            end
          end
        end
        REQ_TICK: begin
          if (phase_q != PH_IDLE) begin
            ev.tick      = 1'b1;
            ev.wait_over = (quiet_inc >= limit);
          end
        end
        default: ;
      endcase
    end

    if (ev.wait_over) begin
      ev.enter = 1'b1;
      case (phase_q)
        PH_DISABLE: begin
          if (op_q == OP_SELFTEST) begin
            ev.next_phase = PH_RESET;
            ev.send       = 1'b1;
            ev.send_byte  = BYTE_RESET;
          end else begin
            ev.finish    = 1'b1;
            ev.finish_ok = 1'b1;
          end
        end
        PH_RESET: ev.next_phase = PH_RESULT;
        PH_RESULT: begin
          if (ev.fail) begin
            ev.finish = 1'b1;
          end else begin
            ev.next_phase = PH_DRAIN;
          end
        end
        default: begin
          ev.finish    = 1'b1;
          ev.finish_ok = 1'b1;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    port_d  = port_q;
    retry_d = retry_q;
    quiet_d = quiet_q;
    if (ev.start) begin
      op_d   = req_i.operation;
      port_d = (req_i.target_port == PORT_AUX);
    end
    if (ev.rx) quiet_d = '0;
    if (ev.tick) quiet_d = quiet_inc;
    if (ev.retry) retry_d = retry_q + RETRY_W'(1);
    if (ev.enter) begin
      phase_d = ev.next_phase;
      quiet_d = '0;
      retry_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= '0;
      port_q  <= 1'b0;
      retry_q <= '0;
      quiet_q <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      port_q  <= port_d;
      retry_q <= retry_d;
      quiet_q <= quiet_d;
    end
  end

  // results of the accepted item
  assign send_aux = ev.start ? (req_i.target_port == PORT_AUX) : port_q;

  always_comb begin
    n_res = 2'd0;
    res0  = '0;
    res1  = '0;
    if (ev.send) begin
      if (send_aux) begin
        res0.action      = ACT_CMD;
        res0.byte_value  = BYTE_AUX_PREFIX;
        res1.action      = ACT_DATA;
        res1.byte_value  = ev.send_byte;
        res1.last_of_run = 1'b1;
        n_res            = 2'd2;
      end else begin
        res0.action      = ACT_DATA;
        res0.byte_value  = ev.send_byte;
        res0.last_of_run = 1'b1;
        n_res            = 2'd1;
      end
    end else if (ev.finish) begin
      res0.action      = ACT_DONE;
      res0.passed      = ev.finish_ok;
      res0.last_of_run = 1'b1;
      n_res            = 2'd1;
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) queue_q[wr_ptr_q] <= res0;
    if (n_res == 2'd2) queue_q[wr_ptr_q + QUEUE_PTR_W'(1)] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(n_res);
      if (pop) rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      count_q  <= count_q + QUEUE_CNT_W'(n_res) - QUEUE_CNT_W'(pop);
    end
  end

  assign rsp_o.valid       = (count_q != '0);
  assign rsp_o.action      = queue_q[rd_ptr_q].action;
  assign rsp_o.byte_value  = queue_q[rd_ptr_q].byte_value;
  assign rsp_o.passed      = queue_q[rd_ptr_q].passed;
  assign rsp_o.last_of_run = queue_q[rd_ptr_q].last_of_run;

endmodule

>>> rtl/ps2dcrs_checker.sv
// Checker: port-level assertions for the PS/2 device command sequencer.
module ps2dcrs_checker
  import ps2dcrs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_action_i,
  input logic [7:0] rsp_byte_i,
  input logic       rsp_passed_i,
  input logic       rsp_last_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_action_i)
      && $stable(rsp_byte_i) && $stable(rsp_last_i))
    else $error("result changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_action_i == ACT_DONE |-> rsp_last_i && rsp_byte_i == 8'h00)
    else $error("finish result malformed");

  a_write_not_passed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_action_i != ACT_DONE |-> !rsp_passed_i)
    else $error("write result with passed set");

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_action_i == ACT_CMD |-> rsp_byte_i == BYTE_AUX_PREFIX && !rsp_last_i)
    else $error("bad auxiliary prefix result");

  a_prefix_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i && rsp_action_i == ACT_CMD |=>
      rsp_valid_i && rsp_action_i == ACT_DATA)
    else $error("prefix not followed by data byte");

endmodule

bind ps2_device_command_retry_sequencer_unit ps2dcrs_checker u_ps2dcrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_action_i (rsp_o.action),
  .rsp_byte_i   (rsp_o.byte_value),
  .rsp_passed_i (rsp_o.passed),
  .rsp_last_i   (rsp_o.last_of_run)
);
